[src/u8dec_pkg.sv]
// Shared types and constants for the UTF-8 stream decoder and validator.
package u8dec_pkg;

  localparam int unsigned PositionBitsDefault = 32;
  localparam int unsigned QueueDepthDefault   = 4;
  localparam int unsigned OutPosBits          = 32;
  localparam int unsigned CodePointBits       = 21;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] LeadMin    = 8'hc2;
  localparam logic [7:0] Lead2Max   = 8'hdf;
  localparam logic [7:0] Lead3Max   = 8'hef;
  localparam logic [7:0] LeadMax    = 8'hf4;
  localparam logic [7:0] LeadE0     = 8'he0;
  localparam logic [7:0] LeadED     = 8'hed;
  localparam logic [7:0] LeadF0     = 8'hf0;
  localparam logic [7:0] LeadF4     = 8'hf4;
  localparam logic [7:0] ContA0     = 8'ha0;
  localparam logic [7:0] Cont9F     = 8'h9f;
  localparam logic [7:0] Cont90     = 8'h90;
  localparam logic [7:0] Cont8F     = 8'h8f;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StInvStart    = 2'd1,
    StInvCont     = 2'd2,
    StUnexpEnd    = 2'd3
  } status_e;

  typedef enum logic {
    KindCodePoint = 1'b0,
    KindStatus    = 1'b1
  } kind_e;

  // One queue entry: everything a single input byte produces
  typedef struct packed {
    logic                     has_cp;
    logic [CodePointBits-1:0] cp;
    logic                     has_status;
    status_e                  status;
    logic [OutPosBits-1:0]    err_start;
    logic [OutPosBits-1:0]    err_end;
  } entry_t;

endpackage

[src/u8dec_if.sv]
// Channel interfaces: byte input and result output.
interface u8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8dec_out_if;
  logic                                   valid;
  logic                                   ready;
  u8dec_pkg::kind_e                       result_kind;
  logic [u8dec_pkg::CodePointBits-1:0]    code_point;
  u8dec_pkg::status_e                     status;
  logic [u8dec_pkg::OutPosBits-1:0]       error_start;
  logic [u8dec_pkg::OutPosBits-1:0]       error_end;
  logic                                   last_of_run;

  modport source (output valid, output result_kind, output code_point, output status,
                  output error_start, output error_end, output last_of_run, input ready);
  modport sink   (input valid, input result_kind, input code_point, input status,
                  input error_start, input error_end, input last_of_run, output ready);
endinterface

[src/utf8_stream_decoder_validator_unit.sv]
// Top level of the UTF-8 stream decoder and validator.
//
// in_i takes one text byte per item, with end_of_text on the final byte of a text.
// out_o gives result items: a code point for each completed scalar value, and on
// the final byte a status item (ok, invalid start, invalid continuation, unexpected
// end) with the error span; last_of_run marks the final item caused by a byte.
// A byte is taken every cycle while the entry queue has room. Most bytes give at
// most one item; a final byte that also completes a sequence gives two, and the
// result stage then sends the code point item ahead of the status item.
// An accepted byte's first result item goes through the queue write, then the output register.
// When out_o stalls, items build up in the QueueDepth-entry queue; once it is
// full in_i.ready falls. Bytes that give no result take no queue space.
// Reset clears the position counter, any open sequence and any latched error, so
// the next byte starts a new text at position 0, as it also does after each
// end-of-text byte. Positions wrap at 2^PositionBits and report their low 32 bits.
module utf8_stream_decoder_validator_unit #(
  parameter int unsigned PositionBits = u8dec_pkg::PositionBitsDefault,
  parameter int unsigned QueueDepth   = u8dec_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  u8dec_in_if.sink    in_i,
  u8dec_out_if.source out_o
);

  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  u8dec_pkg::entry_t  push_entry, head_entry;
  logic               push, pop, empty, full, pend;
  logic [CntBits-1:0] count;

  u8dec_front #(
    .PositionBits (PositionBits)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  u8dec_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (empty),
    .full_o  (full),
    .count_o (count)
  );

  u8dec_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (empty),
    .pop_o   (pop),
    .pend_o  (pend),
    .out_o   (out_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntBits'(QueueDepth))
    else $error("entry queue count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("entry pushed into full queue");

  a_pending_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend |-> (out_o.valid && out_o.result_kind == u8dec_pkg::KindCodePoint &&
              !out_o.last_of_run))
    else $error("pending status without a code point item ahead of it");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == u8dec_pkg::KindStatus) |-> out_o.last_of_run)
    else $error("status item not marked last of run");

  a_cp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == u8dec_pkg::KindCodePoint) |->
      (out_o.status == u8dec_pkg::StOk && out_o.error_start == '0 && out_o.error_end == '0))
    else $error("code point item carries status fields");

endmodule

[src/u8dec_front.sv]
// Front end: takes bytes, runs the sequence checks and pushes one entry per result-bearing byte.
module u8dec_front #(
  parameter int unsigned PositionBits = u8dec_pkg::PositionBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8dec_in_if.sink          in_i,
  input  logic              full_i,
  output logic              push_o,
  output u8dec_pkg::entry_t entry_o
);

  localparam int unsigned OutBits = u8dec_pkg::OutPosBits;

  logic [PositionBits-1:0]              pos_q, pos_d;
  logic [7:0]                           lead_q, lead_d;
  logic [2:0]                           len_q, len_d;
  logic [2:0]                           taken_q, taken_d;
  logic [u8dec_pkg::CodePointBits-1:0]  part_q, part_d;
  logic [PositionBits-1:0]              lead_pos_q, lead_pos_d;
  u8dec_pkg::status_e                   err_q, err_d;
  logic [PositionBits-1:0]              lat_start_q, lat_start_d;
  logic [PositionBits-1:0]              lat_end_q, lat_end_d;

  logic                                 accept;
  logic                                 cont_ok;
  logic [2:0]                           taken_inc;
  logic [7:0]                           b;
  logic [PositionBits-1:0]              span_start, span_end;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.data_byte;
  assign taken_inc  = taken_q + 3'd1;

  always_comb begin
    cont_ok = (b[7:6] == 2'b10);
    if (cont_ok && taken_q == 3'd1) begin
      if (lead_q == u8dec_pkg::LeadE0) begin
        cont_ok = (b >= u8dec_pkg::ContA0);
      end else if (lead_q == u8dec_pkg::LeadED) begin
        cont_ok = (b <= u8dec_pkg::Cont9F);
      end else if (lead_q == u8dec_pkg::LeadF0) begin
        cont_ok = (b >= u8dec_pkg::Cont90);
      end else if (lead_q == u8dec_pkg::LeadF4) begin
        cont_ok = (b <= u8dec_pkg::Cont8F);
      end
    end
  end

  always_comb begin
    pos_d       = pos_q;
    lead_d      = lead_q;
    len_d       = len_q;
    taken_d     = taken_q;
    part_d      = part_q;
    lead_pos_d  = lead_pos_q;
    err_d       = err_q;
    lat_start_d = lat_start_q;
    lat_end_d   = lat_end_q;
    span_start  = lat_start_q;
    span_end    = lat_end_q;
    push_o      = 1'b0;
    entry_o     = '0;

    if (accept) begin
      if (err_q == u8dec_pkg::StOk) begin
        if (len_q == 3'd0) begin
          if (b < u8dec_pkg::AsciiLimit) begin
            entry_o.has_cp = 1'b1;
            entry_o.cp     = {{(u8dec_pkg::CodePointBits-8){1'b0}}, b};
          end else if (b >= u8dec_pkg::LeadMin && b <= u8dec_pkg::LeadMax) begin
            lead_d      = b;
            taken_d     = 3'd1;
            lead_pos_d  = pos_q;
            if (b <= u8dec_pkg::Lead2Max) begin
              len_d  = 3'd2;
              part_d = {{(u8dec_pkg::CodePointBits-5){1'b0}}, b[4:0]};
            end else if (b <= u8dec_pkg::Lead3Max) begin
              len_d  = 3'd3;
              part_d = {{(u8dec_pkg::CodePointBits-4){1'b0}}, b[3:0]};
            end else begin
              len_d  = 3'd4;
              part_d = {{(u8dec_pkg::CodePointBits-3){1'b0}}, b[2:0]};
            end
          end else begin
            err_d       = u8dec_pkg::StInvStart;
            lat_start_d = pos_q;
            lat_end_d   = pos_q;
          end
        end else if (!cont_ok) begin
          // span ends on the last good byte, which is the one just before
          err_d       = u8dec_pkg::StInvCont;
          lat_start_d = lead_pos_q;
          lat_end_d   = pos_q - PositionBits'(1);
          len_d       = 3'd0;
        end else begin
          part_d  = {part_q[u8dec_pkg::CodePointBits-7:0], b[5:0]};
          taken_d = taken_inc;
          if (taken_inc >= len_q) begin
            entry_o.has_cp = 1'b1;
            entry_o.cp     = part_d;
            len_d          = 3'd0;
            taken_d        = 3'd0;
            part_d         = '0;
          end
        end
      end

      if (in_i.end_of_text) begin
        span_start = lat_start_d;
        span_end   = lat_end_d;
        entry_o.status = err_d;
        if (err_d == u8dec_pkg::StOk && len_d != 3'd0) begin
          entry_o.status = u8dec_pkg::StUnexpEnd;
          span_start     = lead_pos_d;
          span_end       = pos_q;
        end
        entry_o.has_status = 1'b1;
        entry_o.err_start  = OutBits'(span_start);
        entry_o.err_end    = OutBits'(span_end);
        pos_d       = '0;
        lead_d      = '0;
        len_d       = '0;
        taken_d     = '0;
        part_d      = '0;
        lead_pos_d  = '0;
        err_d       = u8dec_pkg::StOk;
        lat_start_d = '0;
        lat_end_d   = '0;
      end else begin
        pos_d = pos_q + PositionBits'(1);
      end
      push_o = entry_o.has_cp || entry_o.has_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      lead_q      <= '0;
      len_q       <= '0;
      taken_q     <= '0;
      part_q      <= '0;
      lead_pos_q  <= '0;
      err_q       <= u8dec_pkg::StOk;
      lat_start_q <= '0;
      lat_end_q   <= '0;
    end else begin
      pos_q       <= pos_d;
      lead_q      <= lead_d;
      len_q       <= len_d;
      taken_q     <= taken_d;
      part_q      <= part_d;
      lead_pos_q  <= lead_pos_d;
      err_q       <= err_d;
      lat_start_q <= lat_start_d;
      lat_end_q   <= lat_end_d;
    end
  end

endmodule

[src/u8dec_queue.sv]
// Short entry queue between the front end and the result stage.
module u8dec_queue #(
  parameter int unsigned Depth = u8dec_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  u8dec_pkg::entry_t           entry_i,
  input  logic                        pop_i,
  output u8dec_pkg::entry_t           head_o,
  output logic                        empty_o,
  output logic                        full_o,
  output logic [$clog2(Depth+1)-1:0]  count_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  u8dec_pkg::entry_t  mem_q [Depth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] cnt_q;
  logic               do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntBits'(Depth));
  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrBits'(Depth - 1)) ? '0 : wr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrBits'(Depth - 1)) ? '0 : rd_q + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntBits'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntBits'(1);
      end
    end
  end

endmodule

[src/u8dec_back.sv]
// Result stage: splits each entry into code point and status items behind an output register.
module u8dec_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8dec_pkg::entry_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              pend_o,
  u8dec_out_if.source       out_o
);

  logic                                valid_q, valid_d;
  u8dec_pkg::kind_e                    kind_q, kind_d;
  logic [u8dec_pkg::CodePointBits-1:0] cp_q, cp_d;
  u8dec_pkg::status_e                  st_q, st_d;
  logic [u8dec_pkg::OutPosBits-1:0]    start_q, start_d;
  logic [u8dec_pkg::OutPosBits-1:0]    end_q, end_d;
  logic                                last_q, last_d;
  // status half of an entry whose code point has gone out first
  logic                                pend_q, pend_d;
  u8dec_pkg::status_e                  hst_q, hst_d;
  logic [u8dec_pkg::OutPosBits-1:0]    hstart_q, hstart_d;
  logic [u8dec_pkg::OutPosBits-1:0]    hend_q, hend_d;
  logic                                load;

  assign load  = !valid_q || out_o.ready;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    valid_d  = valid_q;
    kind_d   = kind_q;
    cp_d     = cp_q;
    st_d     = st_q;
    start_d  = start_q;
    end_d    = end_q;
    last_d   = last_q;
    pend_d   = pend_q;
    hst_d    = hst_q;
    hstart_d = hstart_q;
    hend_d   = hend_q;

    if (load) begin
      valid_d = 1'b0;
      if (pend_q) begin
        valid_d = 1'b1;
        kind_d  = u8dec_pkg::KindStatus;
        cp_d    = '0;
        st_d    = hst_q;
        start_d = hstart_q;
        end_d   = hend_q;
        last_d  = 1'b1;
        pend_d  = 1'b0;
      end else if (!empty_i) begin
        valid_d = 1'b1;
        if (head_i.has_cp) begin
          kind_d   = u8dec_pkg::KindCodePoint;
          cp_d     = head_i.cp;
          st_d     = u8dec_pkg::StOk;
          start_d  = '0;
          end_d    = '0;
          last_d   = !head_i.has_status;
          pend_d   = head_i.has_status;
          hst_d    = head_i.status;
          hstart_d = head_i.err_start;
          hend_d   = head_i.err_end;
        end else begin
          kind_d  = u8dec_pkg::KindStatus;
          cp_d    = '0;
          st_d    = head_i.status;
          start_d = head_i.err_start;
          end_d   = head_i.err_end;
          last_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    cp_q     <= cp_d;
    st_q     <= st_d;
    start_q  <= start_d;
    end_q    <= end_d;
    last_q   <= last_d;
    hst_q    <= hst_d;
    hstart_q <= hstart_d;
    hend_q   <= hend_d;
  end

  assign out_o.valid       = valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.code_point  = cp_q;
  assign out_o.status      = st_q;
  assign out_o.error_start = start_q;
  assign out_o.error_end   = end_q;
  assign out_o.last_of_run = last_q;
  assign pend_o            = pend_q;

endmodule

[test/utf8_stream_decoder_validator_unit_tb.sv]
// Self-checking testbench for the UTF-8 stream decoder and validator: directed and random texts.
module utf8_stream_decoder_validator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    u8dec_pkg::kind_e   kind;
    logic [20:0]        cp;
    u8dec_pkg::status_e st;
    logic [31:0]        span_start;
    logic [31:0]        span_end;
    logic               last;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  u8dec_in_if  in_bus ();
  u8dec_out_if out_bus ();

  utf8_stream_decoder_validator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  // Decoder state as seen from outside
  logic [31:0]        pos_cnt   = '0;
  logic [7:0]         lead      = '0;
  logic [2:0]         seq_len   = '0;
  logic [2:0]         taken     = '0;
  logic [20:0]        acc       = '0;
  logic [31:0]        lead_pos  = '0;
  u8dec_pkg::status_e err_code  = u8dec_pkg::StOk;
  logic [31:0]        err_start = '0;
  logic [31:0]        err_end   = '0;

  decoded_t pending_results[$];

  bit idle_on  = 1'b0;
  bit stall_on = 1'b0;
  int stall_left = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int texts_sent = 0;
  int cps_seen   = 0;
  int ends_seen[4] = '{0, 0, 0, 0};

  // Works out the results of one accepted byte and queues them
  function automatic void decode_byte(input logic [7:0] b, input logic eot);
    decoded_t   res[$];
    decoded_t   r;
    logic       ok;
    logic [31:0] here;
    here = pos_cnt;
    r.kind = u8dec_pkg::KindCodePoint;
    r.cp = '0;
    r.st = u8dec_pkg::StOk;
    r.span_start = '0;
    r.span_end = '0;
    r.last = 1'b0;
    if (err_code == u8dec_pkg::StOk) begin
      if (seq_len == 0) begin
        if (b < u8dec_pkg::AsciiLimit) begin
          r.cp = {13'd0, b};
          res.insert(res.size(), r);
        end else if (b >= u8dec_pkg::LeadMin && b <= u8dec_pkg::LeadMax) begin
          lead = b;
          if (b <= u8dec_pkg::Lead2Max) begin
            seq_len = 3'd2;
            acc = {16'd0, b[4:0]};
          end else if (b <= u8dec_pkg::Lead3Max) begin
            seq_len = 3'd3;
            acc = {17'd0, b[3:0]};
          end else begin
            seq_len = 3'd4;
            acc = {18'd0, b[2:0]};
          end
          taken = 3'd1;
          lead_pos = here;
        end else begin
          err_code = u8dec_pkg::StInvStart;
          err_start = here;
          err_end = here;
        end
      end else begin
        ok = (b[7:6] == 2'b10);
        // second byte ranges exclude overlongs, surrogates and values past 10FFFF
        if (ok && taken == 3'd1) begin
          case (lead)
            u8dec_pkg::LeadE0: ok = (b >= u8dec_pkg::ContA0);
            u8dec_pkg::LeadED: ok = (b <= u8dec_pkg::Cont9F);
            u8dec_pkg::LeadF0: ok = (b >= u8dec_pkg::Cont90);
            u8dec_pkg::LeadF4: ok = (b <= u8dec_pkg::Cont8F);
            default: ;
          endcase
        end
        if (!ok) begin
          err_code = u8dec_pkg::StInvCont;
          err_start = lead_pos;
          err_end = lead_pos + {29'd0, taken} - 32'd1;
          seq_len = '0;
        end else begin
          acc = {acc[14:0], b[5:0]};
          taken = taken + 3'd1;
          if (taken >= seq_len) begin
            r.cp = acc;
            res.insert(res.size(), r);
            seq_len = '0;
            taken = '0;
            acc = '0;
          end
        end
      end
    end
    if (eot) begin
      if (err_code == u8dec_pkg::StOk && seq_len != 0) begin
        err_code = u8dec_pkg::StUnexpEnd;
        err_start = lead_pos;
        err_end = here;
      end
      r.kind = u8dec_pkg::KindStatus;
      r.cp = '0;
      r.st = err_code;
      r.span_start = err_start;
      r.span_end = err_end;
      res.insert(res.size(), r);
      ends_seen[err_code]++;
      pos_cnt = '0;
      lead = '0;
      seq_len = '0;
      taken = '0;
      acc = '0;
      lead_pos = '0;
      err_code = u8dec_pkg::StOk;
      err_start = '0;
      err_end = '0;
    end else begin
      pos_cnt = here + 32'd1;
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[k]) begin
      if (res[k].kind == u8dec_pkg::KindCodePoint) cps_seen++;
      pending_results.insert(pending_results.size(), res[k]);
    end
  endfunction

  function automatic void flag_mismatch(input string what, input decoded_t want,
                                        input decoded_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected kind=%0d cp=%h st=%0d span=%0d..%0d last=%0b",
               want.kind, want.cp, want.st, want.span_start, want.span_end, want.last);
      $display("  actual   kind=%0d cp=%h st=%0d span=%0d..%0d last=%0b",
               got.kind, got.cp, got.st, got.span_start, got.span_end, got.last);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    decoded_t want;
    decoded_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.kind = out_bus.result_kind;
      got.cp = out_bus.code_point;
      got.st = out_bus.status;
      got.span_start = out_bus.error_start;
      got.span_end = out_bus.error_end;
      got.last = out_bus.last_of_run;
      if (pending_results.size() == 0) begin
        want = got;
        flag_mismatch("result with nothing expected", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.cp !== want.cp || got.st !== want.st ||
            got.span_start !== want.span_start || got.span_end !== want.span_end ||
            got.last !== want.last)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Result side back-pressure in bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_bus.ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // Returns at the accepting edge; valid stays up for a following item
  task automatic send_byte(input logic [7:0] b, input logic eot);
    int gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.end_of_text <= eot;
    do @(posedge clk_i); while (!in_bus.ready);
    decode_byte(b, eot);
    bytes_sent++;
    if (eot) texts_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  // Text packed first byte highest, n bytes long; end of text on the last
  task automatic send_text(input logic [255:0] txt, input int n);
    for (int i = 0; i < n; i++) send_byte(txt[8*(n-1-i) +: 8], i == n - 1);
  endtask

  task automatic test_valid_sequences();
    // ends on the byte that completes a four-byte sequence: two results
    send_text({8'h00, 8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf, 8'he0, 8'ha0, 8'h80, 8'hed,
               8'h9f, 8'hbf, 8'hf0, 8'h90, 8'h80, 8'h80, 8'hf4, 8'h8f, 8'hbf, 8'hbf}, 20);
  endtask

  task automatic test_invalid_start();
    send_text({8'h80, 8'hff}, 2);
    send_text({8'h41, 8'hc1}, 2);
    send_text({8'hf5}, 1);
  endtask

  task automatic test_invalid_continuation();
    send_text({8'he0, 8'h9f}, 2);
    send_text({8'h41, 8'hed, 8'ha0, 8'hc0}, 4);
    send_text({8'hf0, 8'h8f}, 2);
    send_text({8'hf4, 8'h90}, 2);
    send_text({8'he1, 8'h80, 8'h41}, 3);
  endtask

  task automatic test_unexpected_end();
    send_text({8'hf1, 8'h80, 8'h80}, 3);
    send_text({8'hc3}, 1);
  endtask

  // Mostly well-formed scalars, with stray bytes, corruption and truncation
  task automatic send_random_text();
    logic [7:0]  txt[$];
    logic [7:0]  seq[$];
    logic [20:0] cp;
    int          n_seq;
    int          mode;
    n_seq = $urandom_range(1, 10);
    for (int i = 0; i < n_seq; i++) begin
      mode = $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 9))
          0: cp = 21'h0;
          1: cp = 21'h7f;
          2: cp = 21'h80;
          3: cp = 21'h7ff;
          4: cp = 21'h800;
          5: cp = 21'hd7ff;
          6: cp = 21'he000;
          7: cp = 21'hffff;
          8: cp = 21'h10000;
          default: cp = 21'h10ffff;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0, 1: cp = 21'($urandom_range(0, 'h7f));
          2: cp = 21'($urandom_range('h80, 'h7ff));
          3: begin
            cp = 21'($urandom_range('h800, 'hffff));
            if (cp[15:11] == 5'b11011) cp[14] = 1'b0;  // steer off surrogates
          end
          default: cp = 21'($urandom_range('h10000, 'h10ffff));
        endcase
      end
      seq.delete();
      if (cp < 21'h80) begin
        seq.insert(seq.size(), cp[7:0]);
      end else if (cp < 21'h800) begin
        seq.insert(seq.size(), {3'b110, cp[10:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end else if (cp < 21'h10000) begin
        seq.insert(seq.size(), {4'b1110, cp[15:12]});
        seq.insert(seq.size(), {2'b10, cp[11:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end else begin
        seq.insert(seq.size(), {5'b11110, cp[20:18]});
        seq.insert(seq.size(), {2'b10, cp[17:12]});
        seq.insert(seq.size(), {2'b10, cp[11:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
      if (mode == 0) begin
        seq.delete();
        seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end else if (mode == 1 && seq.size() > 1) begin
        seq[$urandom_range(1, seq.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (mode == 2 && seq.size() > 1) begin
        seq.delete(seq.size() - 1);
      end else if (mode == 3) begin
        // range-checked leads with any continuation as second byte
        seq.delete();
        case ($urandom_range(0, 3))
          0: seq.insert(seq.size(), u8dec_pkg::LeadE0);
          1: seq.insert(seq.size(), u8dec_pkg::LeadED);
          2: seq.insert(seq.size(), u8dec_pkg::LeadF0);
          default: seq.insert(seq.size(), u8dec_pkg::LeadF4);
        endcase
        repeat ((seq[0] >= u8dec_pkg::LeadF0) ? 3 : 2)
          seq.insert(seq.size(), 8'($urandom_range('h80, 'hbf)));
      end
      foreach (seq[k]) txt.insert(txt.size(), seq[k]);
    end
    foreach (txt[k]) send_byte(txt[k], k == txt.size() - 1);
  endtask

  task automatic test_random_texts(input int upto, input bit quiet);
    while (bytes_sent < upto) begin
      idle_on  = !quiet && ($urandom_range(0, 3) != 0);
      stall_on = !quiet && ($urandom_range(0, 3) != 0);
      send_random_text();
    end
  endtask

  task automatic test_drain_pause();
    drop_valid();
    stall_on = 1'b1;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int guard;
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.end_of_text = 1'b0;
    out_bus.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_valid_sequences();
    test_invalid_start();
    test_invalid_continuation();
    test_unexpected_end();
    test_random_texts(800, 1'b0);
    test_drain_pause();
    test_random_texts(1530, 1'b0);
    test_random_texts(1990, 1'b1);
    drop_valid();
    stall_on = 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end

    $display("Sent %0d texts in %0d bytes; %0d code points predicted.",
             texts_sent, bytes_sent, cps_seen);
    $display("Text endings: %0d ok, %0d invalid start, %0d invalid continuation, %0d cut short.",
             ends_seen[0], ends_seen[1], ends_seen[2], ends_seen[3]);
    if (mismatches == 0) begin
      $display("** utf8_stream_decoder_validator_unit: PASSED **");
    end else begin
      $display("%0d failures", mismatches);
      $display("** utf8_stream_decoder_validator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out");
    $display("** utf8_stream_decoder_validator_unit: FAILED **");
    $finish;
  end

endmodule
